@@ hdl/fpt_pkg.sv @@
// Package for the foot placement target block: constants, register codes and
// shared fixed-point helpers. No dependencies.
`default_nettype none
package fpt_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int LEAD_LAT      = 5;
    localparam int ANG_LAT       = 5;

    localparam logic [16:0] PHASE_ONE   = 17'd65536;
    localparam logic [33:0] Q30_TWO_PI  = 34'd6746518852;
    localparam logic [31:0] Q30_PI      = 32'd3373259426;
    localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;
    localparam logic [29:0] CORDIC_K    = 30'd652032874;
    // floor(2^62 / 2pi_q30): estimate of the turn count, corrected afterward
    localparam logic [29:0] RECIP_TWO_PI = 30'd683565275;
    localparam int          RECIP_SHIFT  = 48;
    localparam int          EXTRA_BITS   = 14;

    localparam logic [30:0] SWING_RST = 31'd19661;
    localparam logic [30:0] STANCE_RST = 31'd19661;
    localparam logic [30:0] GAIN_RST  = 31'd328;

    typedef enum logic [2:0] {
        REG_SWING   = 3'd0,
        REG_STANCE  = 3'd1,
        REG_GAIN_X  = 3'd2,
        REG_GAIN_Y  = 3'd3,
        REG_GAIN_YAW = 3'd4,
        REG_SLOPE_X = 3'd5,
        REG_SLOPE_Y = 3'd6
    } t_reg_idx;

    function automatic logic signed [31:0] f_sat32(input logic signed [71:0] x);
        if (x > 72'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -72'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [71:0] f_rnd(input logic signed [71:0] x, input int n);
        logic signed [71:0] h;
        h = 72'sd1 <<< (n - 1);
        return (x + h) >>> n;
    endfunction

    function automatic logic [29:0] f_atan(input int i);
        case (i)
            0:  return 30'd843314857;
            1:  return 30'd497837829;
            2:  return 30'd263043837;
            3:  return 30'd133525159;
            4:  return 30'd67021687;
            5:  return 30'd33543516;
            6:  return 30'd16775851;
            7:  return 30'd8388437;
            8:  return 30'd4194283;
            9:  return 30'd2097149;
            10: return 30'd1048576;
            default: return 30'd1 << (30 - i);
        endcase
    endfunction

endpackage
`default_nettype wire

@@ hdl/fpt_ifs.sv @@
// Channel interfaces for the foot placement target block: request, result and
// register write. No dependencies.
`default_nettype none
interface fpt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] home_foot_x;
    logic signed [31:0] home_foot_y;
    logic signed [31:0] goal_vx;
    logic signed [31:0] goal_vy;
    logic signed [31:0] goal_yaw_rate;
    logic        [16:0] swing_phase;
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_yaw;
    logic signed [31:0] body_yaw_rate;
    logic signed [31:0] body_px;
    logic signed [31:0] body_py;
    modport source (output valid, home_foot_x, home_foot_y, goal_vx, goal_vy,
                    goal_yaw_rate, swing_phase, body_vx, body_vy, body_yaw,
                    body_yaw_rate, body_px, body_py, input ready);
    modport sink (input valid, home_foot_x, home_foot_y, goal_vx, goal_vy,
                  goal_yaw_rate, swing_phase, body_vx, body_vy, body_yaw,
                  body_yaw_rate, body_px, body_py, output ready);
endinterface

interface fpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] foot_x;
    logic signed [31:0] foot_y;
    logic signed [31:0] foot_z;
    modport source (output valid, foot_x, foot_y, foot_z, input ready);
    modport sink (input valid, foot_x, foot_y, foot_z, output ready);
endinterface

interface fpt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/fpt_lead.sv @@
// One lead term: v*(1-phase)*swing + v*stance/2 + gain*err, saturated.
// Five register stages. Depends on fpt_pkg.
`default_nettype none
module fpt_lead
    import fpt_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_en,
    input  wire signed  [31:0] i_v,
    input  wire         [16:0] i_rem,
    input  wire         [30:0] i_gain,
    input  wire signed  [32:0] i_err,
    input  wire         [30:0] i_swing,
    input  wire         [30:0] i_stance,
    output logic signed [31:0] o_lead
);
    logic signed [49:0] r_p1;
    logic signed [63:0] r_p2;
    logic signed [64:0] r_p3;
    logic signed [31:0] r_t1a, r_t2a, r_t3a;
    logic signed [63:0] r_p4;
    logic signed [31:0] r_t2b, r_t3b;
    logic signed [31:0] r_t1, r_t2c, r_t3c;
    logic signed [31:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= i_v * $signed({1'b0, i_rem});
            r_p2  <= i_v * $signed({1'b0, i_stance});
            r_p3  <= $signed({1'b0, i_gain}) * i_err;
            r_t1a <= f_sat32(f_rnd(72'(r_p1), 16));
            r_t2a <= f_sat32(f_rnd(72'(r_p2), 17));  // stance/2 folded in
            r_t3a <= f_sat32(f_rnd(72'(r_p3), 16));
            r_p4  <= r_t1a * $signed({1'b0, i_swing});
            r_t2b <= r_t2a;
            r_t3b <= r_t3a;
            r_t1  <= f_sat32(f_rnd(72'(r_p4), 16));
            r_t2c <= r_t2b;
            r_t3c <= r_t3b;
            r_sum <= f_sat32(72'(r_t1) + 72'(r_t2c) + 72'(r_t3c));
        end
    end

    assign o_lead = r_sum;
endmodule
`default_nettype wire

@@ hdl/fpt_angle.sv @@
// Angle reduction to [-pi/2, pi/2] in Q2.30 with quadrant fold, and vector
// prescale by the CORDIC gain. Five register stages. Depends on fpt_pkg.
`default_nettype none
module fpt_angle
    import fpt_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_en,
    input  wire signed  [31:0] i_yaw,
    input  wire signed  [31:0] i_lead,
    input  wire signed  [31:0] i_hx,
    input  wire signed  [31:0] i_hy,
    output logic signed [47:0] o_x,
    output logic signed [47:0] o_y,
    output logic signed [34:0] o_z
);
    localparam logic signed [50:0] TWO_PI_W = 51'($signed({1'b0, Q30_TWO_PI}));
    localparam logic signed [34:0] TWO_PI_S = 35'($signed({1'b0, Q30_TWO_PI}));
    localparam logic signed [34:0] PI_S     = 35'($signed({1'b0, Q30_PI}));
    localparam logic signed [34:0] HALF_S   = 35'($signed({1'b0, Q30_HALF_PI}));

    logic signed [32:0] r_a1, r_a2, r_a3;
    logic signed [62:0] r_px, r_py;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_x2, r_y2, r_x3, r_y3, r_x4, r_y4, r_x5, r_y5;
    logic signed [50:0] r_qm;
    logic signed [34:0] r_r, r_z5;
    logic signed [15:0] w_q;
    logic signed [50:0] w_d, w_dc;
    logic signed [34:0] w_z, w_zf;
    logic               w_neg;

    assign w_q = r_prod[63:RECIP_SHIFT];

    always_comb begin
        w_d = 51'($signed({r_a3, {EXTRA_BITS{1'b0}}})) - r_qm;
        // turn count estimate is off by at most one
        if (w_d < 0) begin
            w_dc = w_d + TWO_PI_W;
        end else if (w_d >= TWO_PI_W) begin
            w_dc = w_d - TWO_PI_W;
        end else begin
            w_dc = w_d;
        end
    end

    always_comb begin
        w_z   = (r_r > PI_S) ? r_r - TWO_PI_S : r_r;
        w_neg = 1'b0;
        w_zf  = w_z;
        if (w_z > HALF_S) begin
            w_neg = 1'b1;
            w_zf  = w_z - PI_S;
        end else if (w_z < -HALF_S) begin
            w_neg = 1'b1;
            w_zf  = w_z + PI_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1   <= 33'(i_yaw) + 33'(i_lead);
            r_px   <= i_hx * $signed({1'b0, CORDIC_K});
            r_py   <= i_hy * $signed({1'b0, CORDIC_K});
            r_prod <= r_a1 * $signed({1'b0, RECIP_TWO_PI});
            r_a2   <= r_a1;
            r_x2   <= 48'(f_rnd(72'(r_px), 16));
            r_y2   <= 48'(f_rnd(72'(r_py), 16));
            r_qm   <= w_q * $signed({1'b0, Q30_TWO_PI});
            r_a3   <= r_a2;
            r_x3   <= r_x2;
            r_y3   <= r_y2;
            r_r    <= 35'(w_dc);
            r_x4   <= r_x3;
            r_y4   <= r_y3;
            r_z5   <= w_zf;
            r_x5   <= w_neg ? -r_x4 : r_x4;
            r_y5   <= w_neg ? -r_y4 : r_y4;
        end
    end

    assign o_x = r_x5;
    assign o_y = r_y5;
    assign o_z = r_z5;
endmodule
`default_nettype wire

@@ hdl/fpt_cordic.sv @@
// Rotation-mode CORDIC, one register stage per iteration.
// Depends on fpt_pkg.
`default_nettype none
module fpt_cordic
    import fpt_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_en,
    input  wire signed  [47:0] i_x,
    input  wire signed  [47:0] i_y,
    input  wire signed  [34:0] i_z,
    output logic signed [47:0] o_x,
    output logic signed [47:0] o_y
);
    logic signed [47:0] s_x [0:CORDIC_STAGES];
    logic signed [47:0] s_y [0:CORDIC_STAGES];
    logic signed [34:0] s_z [0:CORDIC_STAGES];

    assign s_x[0] = i_x;
    assign s_y[0] = i_y;
    assign s_z[0] = i_z;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [34:0] ATAN = $signed({5'b0, f_atan(k)});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_z[k][34]) begin
                    s_x[k+1] <= s_x[k] - (s_y[k] >>> k);
                    s_y[k+1] <= s_y[k] + (s_x[k] >>> k);
                    s_z[k+1] <= s_z[k] - ATAN;
                end else begin
                    s_x[k+1] <= s_x[k] + (s_y[k] >>> k);
                    s_y[k+1] <= s_y[k] - (s_x[k] >>> k);
                    s_z[k+1] <= s_z[k] + ATAN;
                end
            end
        end
    end

    assign o_x = s_x[CORDIC_STAGES];
    assign o_y = s_y[CORDIC_STAGES];
endmodule
`default_nettype wire

@@ hdl/foot_placement_target_unit.sv @@
// A request passes through the lead terms, angle reduction, CORDIC and output register.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the result register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// Depends on fpt_pkg, fpt_ifs, fpt_lead, fpt_angle, fpt_cordic.
`default_nettype none
module foot_placement_target_unit
    import fpt_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    fpt_in_if.sink   i_in,
    fpt_cfg_if.sink  i_cfg,
    fpt_out_if.source o_out
);
    localparam int LAT     = LEAD_LAT + ANG_LAT + CORDIC_STAGES + 1;
    localparam int D_HOME  = LEAD_LAT;
    localparam int D_POS   = LAT - 1;
    localparam int D_OFS   = ANG_LAT + CORDIC_STAGES;
    localparam int D_FZ    = D_OFS - 1;

    logic [30:0]        r_swing, r_stance, r_gain_x, r_gain_y, r_gain_yaw;
    logic signed [31:0] r_slope_x, r_slope_y;
    logic [LAT-1:0]     r_vld;
    logic               w_en;
    logic [16:0]        w_rem;

    logic signed [31:0] r_yaw_d [0:D_HOME-1];
    logic signed [31:0] r_hx_d  [0:D_HOME-1];
    logic signed [31:0] r_hy_d  [0:D_HOME-1];
    logic signed [31:0] r_px_d  [0:D_POS-1];
    logic signed [31:0] r_py_d  [0:D_POS-1];
    logic signed [31:0] r_ox_d  [0:D_OFS-1];
    logic signed [31:0] r_oy_d  [0:D_OFS-1];
    logic signed [31:0] r_fz_d  [0:D_FZ-1];
    logic signed [63:0] r_pzx, r_pzy;
    logic signed [31:0] r_fx, r_fy, r_fz;

    logic signed [31:0] w_ox, w_oy, w_oyaw;
    logic signed [47:0] w_ax, w_ay, w_cx, w_cy;
    logic signed [34:0] w_az;

    assign w_en  = !r_vld[LAT-1] || o_out.ready;
    assign w_rem = PHASE_ONE - ((i_in.swing_phase > PHASE_ONE) ? PHASE_ONE : i_in.swing_phase);

    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing    <= SWING_RST;
            r_stance   <= STANCE_RST;
            r_gain_x   <= GAIN_RST;
            r_gain_y   <= GAIN_RST;
            r_gain_yaw <= GAIN_RST;
            r_slope_x  <= '0;
            r_slope_y  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SWING:    r_swing    <= i_cfg.data[30:0];
                REG_STANCE:   r_stance   <= i_cfg.data[30:0];
                REG_GAIN_X:   r_gain_x   <= i_cfg.data[30:0];
                REG_GAIN_Y:   r_gain_y   <= i_cfg.data[30:0];
                REG_GAIN_YAW: r_gain_yaw <= i_cfg.data[30:0];
                REG_SLOPE_X:  r_slope_x  <= $signed(i_cfg.data);
                REG_SLOPE_Y:  r_slope_y  <= $signed(i_cfg.data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    fpt_lead u_lead_x (
        .i_clk(i_clk), .i_en(w_en), .i_v(i_in.body_vx), .i_rem(w_rem),
        .i_gain(r_gain_x), .i_err(33'(i_in.body_vx) - 33'(i_in.goal_vx)),
        .i_swing(r_swing), .i_stance(r_stance), .o_lead(w_ox)
    );
    fpt_lead u_lead_y (
        .i_clk(i_clk), .i_en(w_en), .i_v(i_in.body_vy), .i_rem(w_rem),
        .i_gain(r_gain_y), .i_err(33'(i_in.body_vy) - 33'(i_in.goal_vy)),
        .i_swing(r_swing), .i_stance(r_stance), .o_lead(w_oy)
    );
    fpt_lead u_lead_yaw (
        .i_clk(i_clk), .i_en(w_en), .i_v(i_in.body_yaw_rate), .i_rem(w_rem),
        .i_gain(r_gain_yaw),
        .i_err(33'(i_in.goal_yaw_rate) - 33'(i_in.body_yaw_rate)),
        .i_swing(r_swing), .i_stance(r_stance), .o_lead(w_oyaw)
    );

    fpt_angle u_angle (
        .i_clk(i_clk), .i_en(w_en), .i_yaw(r_yaw_d[D_HOME-1]), .i_lead(w_oyaw),
        .i_hx(r_hx_d[D_HOME-1]), .i_hy(r_hy_d[D_HOME-1]),
        .o_x(w_ax), .o_y(w_ay), .o_z(w_az)
    );

    fpt_cordic u_cordic (
        .i_clk(i_clk), .i_en(w_en), .i_x(w_ax), .i_y(w_ay), .i_z(w_az),
        .o_x(w_cx), .o_y(w_cy)
    );

    // side data travels alongside the rotator
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_yaw_d[0] <= i_in.body_yaw;
            r_hx_d[0]  <= i_in.home_foot_x;
            r_hy_d[0]  <= i_in.home_foot_y;
            for (int k = 1; k < D_HOME; k++) begin
                r_yaw_d[k] <= r_yaw_d[k-1];
                r_hx_d[k]  <= r_hx_d[k-1];
                r_hy_d[k]  <= r_hy_d[k-1];
            end
            r_px_d[0] <= i_in.body_px;
            r_py_d[0] <= i_in.body_py;
            for (int k = 1; k < D_POS; k++) begin
                r_px_d[k] <= r_px_d[k-1];
                r_py_d[k] <= r_py_d[k-1];
            end
            r_ox_d[0] <= w_ox;
            r_oy_d[0] <= w_oy;
            for (int k = 1; k < D_OFS; k++) begin
                r_ox_d[k] <= r_ox_d[k-1];
                r_oy_d[k] <= r_oy_d[k-1];
            end
            r_pzx     <= r_slope_x * w_ox;
            r_pzy     <= r_slope_y * w_oy;
            r_fz_d[0] <= f_sat32(f_rnd(72'(r_pzx), 16) + f_rnd(72'(r_pzy), 16));
            for (int k = 1; k < D_FZ; k++) begin
                r_fz_d[k] <= r_fz_d[k-1];
            end
            r_fx <= f_sat32(72'(r_px_d[D_POS-1]) + 72'(r_ox_d[D_OFS-1])
                            + f_rnd(72'(w_cx), EXTRA_BITS));
            r_fy <= f_sat32(72'(r_py_d[D_POS-1]) + 72'(r_oy_d[D_OFS-1])
                            + f_rnd(72'(w_cy), EXTRA_BITS));
            r_fz <= r_fz_d[D_FZ-1];
        end
    end

    assign o_out.valid  = r_vld[LAT-1];
    assign o_out.foot_x = r_fx;
    assign o_out.foot_y = r_fy;
    assign o_out.foot_z = r_fz;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_vld[0])
        else $error("accepted word not in first stage");
    a_idle_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !i_in.valid) |=> !r_vld[0])
        else $error("word entered without request");
    a_last_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vld[LAT-2]) |=> o_out.valid)
        else $error("result lost before output");
`endif
endmodule
`default_nettype wire
